### rtl/scf_pkg.sv
// Shared types, constants and helpers for the scalar Kalman filter.
// No dependencies; imported by the filter top level.
`timescale 1ns / 1ps

package scf_pkg;

	// Default fractional bit count of the Q formats.
	localparam int FRAC_BITS_DEF = 16;
	// The sample period always carries sixteen fractional bits.
	localparam int PERIOD_BITS = 16;

	// Widths of the configuration port.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROCESS_NOISE     = 2'd0,
		REG_MEASUREMENT_NOISE = 2'd1,
		REG_SAMPLE_PERIOD     = 2'd2
	} reg_idx_t;

	// Register reset values.
	localparam logic [31:0] PROCESS_NOISE_RST = 32'h0001_0000;
	localparam logic [31:0] MEASUREMENT_NOISE_RST = 32'h0002_0000;
	localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd655;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DRIFT,
		S_PRED,
		S_DIV,
		S_CMUL,
		S_CADD,
		S_DONE
	} state_t;

	// Multiplier operand selection.
	typedef enum logic [1:0] {
		MUL_DRIFT,
		MUL_CORR,
		MUL_VAR
	} mul_sel_t;

	// Control bundle from the sequencer output decode to the datapath.
	typedef struct packed {
		logic     load_in;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     pred;
		logic     div_step;
		logic     corr_add;
		logic     out_load;
	} ctrl_t;

	// Clamp a wide signed sum to the signed 32-bit range.
	function automatic logic signed [31:0] sat_est(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > 40'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -40'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

### rtl/scalar_kalman_filter.sv
// One-dimensional Kalman filter with a shared multiplier and a serial divider.
// Depends on scf_pkg for constants, state and control types.
`timescale 1ns / 1ps
//
// Usage:
// - Input channel (in_valid/in_ready) carries a measurement and a control rate,
//   both signed fixed point with FRAC_BITS fractional bits. One transaction in
//   gives exactly one transaction out on the output channel
//   (out_valid/out_ready) with the new estimate and error variance.
// - The configuration port writes process_noise, measurement_noise and
//   sample_period at any edge where cfg_we is high; write only while idle.
// - in_ready is low from input acceptance until the sequencer is back in
//   idle, so no new item is taken before the last one reaches the output register.
// - The run time is set by the gain division, which retires one quotient bit
//   per cycle, and by three passes through the single shared multiplier.
// - Reset loads the register defaults (1.0, 2.0, 655), clears the estimate
//   and variance, and arms the first-item load of the estimate.
// - While a result waits on out_ready, the next item is still accepted and
//   computed; it then holds in its final step until the output register frees.

module scalar_kalman_filter #(
	parameter int FRAC_BITS = scf_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [scf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [scf_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [31:0]                measurement,
	input  logic signed [31:0]                control_rate,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [31:0]                estimate,
	output logic [31:0]                       variance
);

	import scf_pkg::*;

	// Operand B width covers the 16-bit period and the FRAC_BITS+1 gain.
	localparam int BW = (FRAC_BITS + 2 > 18) ? FRAC_BITS + 2 : 18;
	localparam int AW = 34;
	localparam int PW = AW + BW;
	localparam int CW = $clog2(FRAC_BITS + 1);
	localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

	state_t state_q, state_d;
	ctrl_t  ctrl;

	// Configuration registers.
	logic [31:0] pn_q, mn_q;
	logic [15:0] period_q;

	// Filter state.
	logic signed [31:0] est_q;
	logic [31:0]        var_q;
	logic               first_q;

	// Working registers.
	logic signed [31:0]    meas_q, rate_q, x_q;
	logic [31:0]           p_q;
	logic [32:0]           den_q;
	logic [33:0]           rem_q;
	logic [FRAC_BITS:0]    gain_q;
	logic [CW-1:0]         cnt_q;
	logic signed [32:0]    resid_q;
	logic signed [PW-1:0]  prod_q;
	logic                  out_valid_q;
	logic signed [31:0]    out_est_q;
	logic [31:0]           out_var_q;

	// Combinational helpers.
	logic signed [AW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic [FRAC_BITS:0]   one_m_gain;
	logic [32:0]          p_pred_sum;
	logic signed [PW-1:0] drift_sh, corr_sh;
	logic                 div_ge;
	logic [32:0]          div_diff;
	logic [PW-1:0]        var_prod;
	logic [31:0]          p_new;
	logic                 div_last;

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DRIFT;
			end
			S_DRIFT: state_d = S_PRED;
			S_PRED:  state_d = S_DIV;
			S_DIV: begin
				if (div_last) state_d = S_CMUL;
			end
			S_CMUL: state_d = S_CADD;
			S_CADD: state_d = S_DONE;
			S_DONE: begin
				if (!out_valid_q || out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Output decode of the sequencer.
	always_comb begin
		ctrl = '0;
		ctrl.mul_sel = MUL_DRIFT;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				ctrl.load_in = in_valid;
			end
			S_DRIFT: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_sel = MUL_DRIFT;
			end
			S_PRED: ctrl.pred = 1'b1;
			S_DIV:  ctrl.div_step = 1'b1;
			S_CMUL: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_sel = MUL_CORR;
			end
			S_CADD: begin
				ctrl.corr_add = 1'b1;
				ctrl.mul_en = 1'b1;
				ctrl.mul_sel = MUL_VAR;
			end
			S_DONE: ctrl.out_load = !out_valid_q || out_ready;
			default: ctrl = '0;
		endcase
	end

	// Operand selection for the shared multiplier.
	assign one_m_gain = ONE_Q - gain_q;
	always_comb begin
		case (ctrl.mul_sel)
			MUL_DRIFT: begin
				mul_a = {{(AW-32){rate_q[31]}}, rate_q};
				mul_b = {{(BW-16){1'b0}}, period_q};
			end
			MUL_CORR: begin
				mul_a = {{(AW-33){resid_q[32]}}, resid_q};
				mul_b = {{(BW-FRAC_BITS-1){1'b0}}, gain_q};
			end
			MUL_VAR: begin
				mul_a = {2'b00, p_q};
				mul_b = {{(BW-FRAC_BITS-1){1'b0}}, one_m_gain};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Datapath helpers: shifts round toward minus infinity.
	assign p_pred_sum = {1'b0, var_q} + {1'b0, pn_q};
	assign drift_sh = prod_q >>> PERIOD_BITS;
	assign corr_sh = prod_q >>> FRAC_BITS;
	assign div_ge = (den_q != 33'd0) && (rem_q >= {1'b0, den_q});
	assign div_diff = div_ge ? (rem_q[32:0] - den_q) : rem_q[32:0];
	assign div_last = (cnt_q == CW'(FRAC_BITS));
	assign var_prod = prod_q >> FRAC_BITS;
	assign p_new = var_prod[31:0];

	// Control registers: sequencer, configuration, filter state, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pn_q <= PROCESS_NOISE_RST;
			mn_q <= MEASUREMENT_NOISE_RST;
			period_q <= SAMPLE_PERIOD_RST;
			est_q <= '0;
			var_q <= '0;
			first_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_PROCESS_NOISE:     pn_q <= cfg_data;
					REG_MEASUREMENT_NOISE: mn_q <= cfg_data;
					REG_SAMPLE_PERIOD:     period_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (ctrl.load_in && first_q) begin
				est_q <= measurement;
				first_q <= 1'b0;
			end
			if (ctrl.out_load) begin
				est_q <= x_q;
				var_q <= p_new;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of one filter step.
	always_ff @(posedge clk) begin
		if (ctrl.load_in) begin
			meas_q <= measurement;
			rate_q <= control_rate;
		end
		if (ctrl.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		// Predict: the drift moves the estimate, process noise grows the variance.
		if (state_q == S_DRIFT) begin
			p_q <= p_pred_sum[32] ? 32'hFFFF_FFFF : p_pred_sum[31:0];
		end
		if (ctrl.pred) begin
			x_q <= sat_est({{8{est_q[31]}}, est_q} + drift_sh[39:0]);
			den_q <= {1'b0, p_q} + {1'b0, mn_q};
			rem_q <= {2'b00, p_q};
			gain_q <= '0;
			cnt_q <= '0;
		end
		// Gain division, one quotient bit a cycle, most significant first.
		if (ctrl.div_step) begin
			gain_q <= {gain_q[FRAC_BITS-1:0], div_ge};
			rem_q <= {div_diff, 1'b0};
			cnt_q <= cnt_q + CW'(1);
			resid_q <= {meas_q[31], meas_q} - {x_q[31], x_q};
		end
		if (ctrl.corr_add) begin
			x_q <= sat_est({{8{x_q[31]}}, x_q} + corr_sh[39:0]);
		end
		if (ctrl.out_load) begin
			out_est_q <= x_q;
			out_var_q <= p_new;
		end
	end

	assign out_valid = out_valid_q;
	assign estimate = out_est_q;
	assign variance = out_var_q;

endmodule

### rtl/scf_checker.sv
// Port-level checks for the scalar Kalman filter, bound to its top level.
// Depends on the port list of scalar_kalman_filter only.
`timescale 1ns / 1ps

module scf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] estimate,
	input logic [31:0]        variance
);

	// A pending input transaction stays offered.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input valid dropped before acceptance");

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(estimate) && $stable(variance))
		else $error("stalled result changed or vanished");

	// The block is busy right after it takes an item.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("block ready right after an input transaction");

	// A new result only appears after the block has been busy.
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while the block was idle");

endmodule

bind scalar_kalman_filter scf_checker u_scf_checker (.*);
